/* hw/rtl/assert_macros.svh */
// Assertion macros used by the RTL of the filter block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge, masked while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at each rising clock edge, reset included.
`define ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/bqld_pkg.sv */
// Package: register map and coefficient constants of the biquad decimator.
package bqld_pkg;

  // Configuration register word addresses (paddr[3:2])
  typedef enum logic [1:0] {
    REG_FILTER_SELECT = 2'd0,
    REG_DECIM_STEP    = 2'd1,
    REG_MAX_OUTPUTS   = 2'd2
  } reg_addr_t;

  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned CFG_ADDR_W   = 4;
  localparam int unsigned DECIM_W      = 8;
  localparam int unsigned COUNT_W      = 21;
  localparam int unsigned INDEX_W      = 20;
  localparam int unsigned WARM_W       = 2;

  localparam logic [DECIM_W-1:0] DECIM_RESET   = 8'd8;
  localparam logic [COUNT_W-1:0] MAX_OUT_RESET = 21'h100000;

  // Coefficients in units of 1e-15, order b0, b1, b2, a1, a2
  localparam longint unsigned DecScale = 64'd1000000000000000;
  localparam longint COEF_DEC [2][5] = '{
    '{ 64'sd29954582208092, 64'sd59909164416185, 64'sd29954582208092,
       -64'sd1454243586251585, 64'sd574061915083955 },
    '{ 64'sd8442692929080, 64'sd16885385858160, 64'sd8442692929080,
       -64'sd1723776172762509, 64'sd757546944478829 }
  };

  // Scale a decimal constant by 2^frac, rounding half away from zero.
  function automatic longint to_fixed(input longint v, input int frac);
    logic            neg;
    longint unsigned m;
    longint unsigned q;
    longint unsigned r;
    neg = (v < 0);
    m = neg ? longint'(64'd0) - v : v;
    q = m / DecScale;
    r = m % DecScale;
    for (int i = 0; i < frac + 1; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= DecScale) begin
        q = q | 64'd1;
        r = r - DecScale;
      end
    end
    q = (q + 64'd1) >> 1;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // Coefficient ready for the sum: feedback terms come negated.
  function automatic longint coef_fixed(input int set, input int k, input int frac);
    longint c;
    c = to_fixed(COEF_DEC[set][k], frac);
    return (k >= 3) ? -c : c;
  endfunction

endpackage

/* hw/rtl/biquad_lowpass_decimator_core.sv */
// Input and result registers lie between an accepted input request and out_tvalid.
// Throughput: one sample per cycle unless a held result stalls; the filter recursion
// closes through the five parallel coefficient multipliers and the rounding adder.
// Samples that are decimated away or arrive while halted produce no result.
// Reset (rst_n low, synchronous) clears the history, counters, valid flags
// and loads the register defaults: set 0, step 8, limit 1048576.
`include "assert_macros.svh"

module biquad_lowpass_decimator_core
  import bqld_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_FRAC_BITS = 28,
  localparam int IN_TDATA_W    = ((SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W   = ((SAMPLE_WIDTH + INDEX_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // sample_in, zero pad
  input  logic                   in_tuser,   // first_in_record
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // sample_out, out_index, zero pad
  output logic                   out_tuser,  // overflow
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int F  = COEF_FRAC_BITS;
  localparam int CW = F + 2;
  localparam int PW = SW + CW;
  localparam int AW = PW + 3;
  localparam int RW = AW - F;

  localparam logic signed [CW-1:0] K0_B0 = CW'(coef_fixed(0, 0, F));
  localparam logic signed [CW-1:0] K0_B1 = CW'(coef_fixed(0, 1, F));
  localparam logic signed [CW-1:0] K0_B2 = CW'(coef_fixed(0, 2, F));
  localparam logic signed [CW-1:0] K0_A1 = CW'(coef_fixed(0, 3, F));
  localparam logic signed [CW-1:0] K0_A2 = CW'(coef_fixed(0, 4, F));
  localparam logic signed [CW-1:0] K1_B0 = CW'(coef_fixed(1, 0, F));
  localparam logic signed [CW-1:0] K1_B1 = CW'(coef_fixed(1, 1, F));
  localparam logic signed [CW-1:0] K1_B2 = CW'(coef_fixed(1, 2, F));
  localparam logic signed [CW-1:0] K1_A1 = CW'(coef_fixed(1, 3, F));
  localparam logic signed [CW-1:0] K1_A2 = CW'(coef_fixed(1, 4, F));

  localparam logic signed [AW-1:0] RND  = {{(AW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [RW-1:0] SMAX = {{(RW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [RW-1:0] SMIN = {{(RW-SW+1){1'b1}}, {(SW-1){1'b0}}};

  // ---------------- configuration registers ----------------
  logic                filter_sel_r;
  logic [DECIM_W-1:0]  decim_step_r;
  logic [COUNT_W-1:0]  max_outputs_r;
  logic                cfg_wr;
  reg_addr_t           cfg_addr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign cfg_addr = reg_addr_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_sel_r  <= 1'b0;
      decim_step_r  <= DECIM_RESET;
      max_outputs_r <= MAX_OUT_RESET;
    end else if (cfg_wr) begin
      case (cfg_addr)
        REG_FILTER_SELECT: filter_sel_r  <= pwdata[0];
        REG_DECIM_STEP:    decim_step_r  <= pwdata[DECIM_W-1:0];
        REG_MAX_OUTPUTS:   max_outputs_r <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_addr)
      REG_FILTER_SELECT: prdata = CFG_DATA_W'(filter_sel_r);
      REG_DECIM_STEP:    prdata = CFG_DATA_W'(decim_step_r);
      REG_MAX_OUTPUTS:   prdata = CFG_DATA_W'(max_outputs_r);
      default:           prdata = '0;
    endcase
  end

  // ---------------- input register and flow control ----------------
  logic                 in_vld_r;
  logic signed [SW-1:0] in_sample_r;
  logic                 in_first_r;
  logic                 out_vld_r;
  logic                 proc;
  logic                 in_acc;

  assign proc      = in_vld_r & (~out_vld_r | out_tready);
  assign in_tready = ~in_vld_r | proc;
  assign in_acc    = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_sample_r <= in_tdata[SW-1:0];
      in_first_r  <= in_tuser;
    end
  end

  // ---------------- filter state ----------------
  logic signed [SW-1:0] prev_in_1_r, prev_in_2_r, prev_out_1_r, prev_out_2_r;
  logic [WARM_W-1:0]    warm_cnt_r;
  logic [DECIM_W-1:0]   phase_cnt_r;
  logic [COUNT_W-1:0]   emit_cnt_r;
  logic                 halted_r;

  logic signed [SW-1:0] prev_in_1_nxt, prev_in_2_nxt, prev_out_1_nxt, prev_out_2_nxt;
  logic [WARM_W-1:0]    warm_cnt_nxt;
  logic [DECIM_W-1:0]   phase_cnt_nxt;
  logic [COUNT_W-1:0]   emit_cnt_nxt;
  logic                 halted_nxt;

  // record start clears history and counters before the sample is used
  logic signed [SW-1:0] p_in1, p_in2, p_out1, p_out2;
  logic [WARM_W-1:0]    warm_eff;
  logic [DECIM_W-1:0]   phase_eff;
  logic [COUNT_W-1:0]   emit_eff;
  logic                 halt_eff;

  assign p_in1     = in_first_r ? '0 : prev_in_1_r;
  assign p_in2     = in_first_r ? '0 : prev_in_2_r;
  assign p_out1    = in_first_r ? '0 : prev_out_1_r;
  assign p_out2    = in_first_r ? '0 : prev_out_2_r;
  assign warm_eff  = in_first_r ? '0 : warm_cnt_r;
  assign phase_eff = in_first_r ? '0 : phase_cnt_r;
  assign emit_eff  = in_first_r ? '0 : emit_cnt_r;
  assign halt_eff  = in_first_r ? 1'b0 : halted_r;

  // ---------------- datapath: five products, round, saturate ----------------
  logic signed [CW-1:0] k_b0, k_b1, k_b2, k_a1, k_a2;
  logic signed [PW-1:0] p0, p1, p2, p3, p4;
  logic signed [AW-1:0] acc, acc_rnd;
  logic signed [RW-1:0] shifted;
  logic signed [SW-1:0] filt, y;

  assign k_b0 = filter_sel_r ? K1_B0 : K0_B0;
  assign k_b1 = filter_sel_r ? K1_B1 : K0_B1;
  assign k_b2 = filter_sel_r ? K1_B2 : K0_B2;
  assign k_a1 = filter_sel_r ? K1_A1 : K0_A1;
  assign k_a2 = filter_sel_r ? K1_A2 : K0_A2;

  assign p0 = PW'(in_sample_r) * PW'(k_b0);
  assign p1 = PW'(p_in1) * PW'(k_b1);
  assign p2 = PW'(p_in2) * PW'(k_b2);
  assign p3 = PW'(p_out1) * PW'(k_a1);
  assign p4 = PW'(p_out2) * PW'(k_a2);

  assign acc     = AW'(p0) + AW'(p1) + AW'(p2) + AW'(p3) + AW'(p4);
  assign acc_rnd = acc + RND;
  assign shifted = acc_rnd[AW-1:F];

  always_comb begin
    if (shifted > SMAX) begin
      filt = SMAX[SW-1:0];
    end else if (shifted < SMIN) begin
      filt = SMIN[SW-1:0];
    end else begin
      filt = shifted[SW-1:0];
    end
  end

  // warmup samples pass through unfiltered
  assign y = (warm_eff < WARM_W'(2)) ? in_sample_r : filt;

  // ---------------- decimation and counting ----------------
  logic [DECIM_W-1:0] step_eff;
  logic [DECIM_W:0]   phase_inc;
  logic               emit;
  logic               res_vld, res_ovf;
  logic signed [SW-1:0] res_sample;
  logic [INDEX_W-1:0] res_index;

  assign step_eff  = (decim_step_r == '0) ? DECIM_W'(1) : decim_step_r;
  assign phase_inc = {1'b0, phase_eff} + (DECIM_W+1)'(1);
  assign emit      = (phase_eff == '0);

  always_comb begin
    prev_in_1_nxt  = p_in1;
    prev_in_2_nxt  = p_in2;
    prev_out_1_nxt = p_out1;
    prev_out_2_nxt = p_out2;
    warm_cnt_nxt   = warm_eff;
    phase_cnt_nxt  = phase_eff;
    emit_cnt_nxt   = emit_eff;
    halted_nxt     = halt_eff;
    res_vld        = 1'b0;
    res_ovf        = 1'b0;
    res_sample     = y;
    res_index      = emit_eff[INDEX_W-1:0];
    if (!halt_eff) begin
      prev_in_2_nxt  = p_in1;
      prev_in_1_nxt  = in_sample_r;
      prev_out_2_nxt = p_out1;
      prev_out_1_nxt = y;
      if (warm_eff < WARM_W'(2)) begin
        warm_cnt_nxt = warm_eff + WARM_W'(1);
      end
      if (phase_inc >= {1'b0, step_eff}) begin
        phase_cnt_nxt = '0;
      end else begin
        phase_cnt_nxt = phase_inc[DECIM_W-1:0];
      end
      if (emit) begin
        res_vld = 1'b1;
        if (emit_eff >= max_outputs_r) begin
          // limit passed: flag it and drop samples until the next record
          res_ovf    = 1'b1;
          res_sample = '0;
          res_index  = '0;
          halted_nxt = 1'b1;
        end else begin
          emit_cnt_nxt = emit_eff + COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_in_1_r  <= '0;
      prev_in_2_r  <= '0;
      prev_out_1_r <= '0;
      prev_out_2_r <= '0;
      warm_cnt_r   <= '0;
      phase_cnt_r  <= '0;
      emit_cnt_r   <= '0;
      halted_r     <= 1'b0;
    end else if (proc) begin
      prev_in_1_r  <= prev_in_1_nxt;
      prev_in_2_r  <= prev_in_2_nxt;
      prev_out_1_r <= prev_out_1_nxt;
      prev_out_2_r <= prev_out_2_nxt;
      warm_cnt_r   <= warm_cnt_nxt;
      phase_cnt_r  <= phase_cnt_nxt;
      emit_cnt_r   <= emit_cnt_nxt;
      halted_r     <= halted_nxt;
    end
  end

  // ---------------- result register ----------------
  logic signed [SW-1:0] out_sample_r;
  logic [INDEX_W-1:0]   out_index_r;
  logic                 out_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc && res_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_vld) begin
      out_sample_r <= res_sample;
      out_index_r  <= res_index;
      out_ovf_r    <= res_ovf;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TDATA_W'({out_index_r, out_sample_r});
  assign out_tuser  = out_ovf_r;

  // ---------------- assertions ----------------
  `ASSERT_CLK(a_ovf_halts, (proc && res_vld && res_ovf) |=> halted_r, "overflow did not halt")
  `ASSERT_CLK(a_halt_silent, (proc && halted_r && !in_first_r) |=> !out_vld_r, "result while halted")
  `ASSERT_CLK(a_ovf_zero, (out_tvalid && out_tuser) |-> (out_tdata == '0), "overflow carries data")
  `ASSERT_ANY(a_rst_idle, !rst_n |=> (!out_tvalid && in_tready), "channels busy after reset")

endmodule
